### design/cs_pkg.sv
`timescale 1ns / 1ps

package cs_pkg;

    localparam int PORT_W        = 16;
    localparam int DOT_W         = 48;
    localparam int SQ_W          = 44;
    localparam int COS_W         = 16;
    localparam int STATUS_W      = 2;

    localparam int MAX_LEN_DEF   = 4096;
    localparam int ELEM_BITS_DEF = 16;

    // mag^2 (95 bits) scaled by 2^32
    localparam int SCALE_SH      = 32;
    localparam int ALU_W         = 2 * (DOT_W - 1) + 1 + SCALE_SH;
    localparam int QUO_W         = SCALE_SH + 1;
    localparam int ROOT_OP_W     = SCALE_SH;
    localparam int ROOT_W        = ROOT_OP_W / 2;
    localparam int STEP_W        = 6;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_ZERO = 2'd1;
    localparam status_t ST_LEN  = 2'd2;

endpackage

### design/cs_req_if.sv
`timescale 1ns / 1ps

interface cs_req_if;

    logic                              valid;
    logic                              ready;
    logic signed [cs_pkg::PORT_W-1:0]  a_elem;
    logic signed [cs_pkg::PORT_W-1:0]  b_elem;
    logic                              last;

    modport source (output valid, output a_elem, output b_elem, output last, input ready);
    modport sink   (input valid, input a_elem, input b_elem, input last, output ready);

endinterface

### design/cs_rsp_if.sv
`timescale 1ns / 1ps

interface cs_rsp_if;

    logic                              valid;
    logic                              ready;
    logic signed [cs_pkg::COS_W-1:0]   cosine;
    logic signed [cs_pkg::DOT_W-1:0]   dot_product;
    cs_pkg::status_t                   status;

    modport source (output valid, output cosine, output dot_product, output status,
                    input ready);
    modport sink   (input valid, input cosine, input dot_product, input status,
                    output ready);

endinterface

### design/cs_addsub.sv
`timescale 1ns / 1ps

module cs_addsub #(
    parameter int W = cs_pkg::ALU_W
) (
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         carry
);

    logic [W:0] full;

    // carry set on subtract means x >= y
    assign full  = {1'b0, x} + {1'b0, (y ^ {W{sub}})} + {{W{1'b0}}, sub};
    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

### design/cosine_similarity_core.sv
`timescale 1ns / 1ps

// Cosine similarity of two integer vectors.
// req (sink): one element pair per request, last marks the final pair.
// rsp (source): one result per vector: cosine (Q1.15), dot_product, status.
// Each pair goes through acceptance, then three products and three
// accumulations through one shared multiplier and one shared 127-bit
// adder/subtractor; req.ready is low meanwhile.
// A last pair adds the final evaluation, all on the same adder: norm
// checks, shift-add sum_aa*sum_bb, shift-add dot^2, restoring division,
// integer root, then the load of the result register that raises
// rsp.valid.
// Zero norm or too long vectors skip the evaluation.
// Pairs beyond MAX_LEN are dropped at acceptance and flagged with status 2.
// The result register holds while rsp.ready is low; the next vector may be
// accumulated meanwhile, the block waits only when a second result is ready.
// Reset clears all accumulators, the element count and rsp.valid.
module cosine_similarity_core #(
    parameter int MAX_LEN   = cs_pkg::MAX_LEN_DEF,
    parameter int ELEM_BITS = cs_pkg::ELEM_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cs_req_if.sink     req,
    cs_rsp_if.source   rsp
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int RAW_W  = (ELEM_BITS > cs_pkg::PORT_W) ? ELEM_BITS : cs_pkg::PORT_W;
    localparam int AW     = cs_pkg::ALU_W;
    localparam int DW     = cs_pkg::DOT_W;
    localparam int SW     = cs_pkg::SQ_W;
    localparam int QW     = cs_pkg::QUO_W;
    localparam int OW     = cs_pkg::ROOT_OP_W;
    localparam int RW     = cs_pkg::ROOT_W;
    localparam int TW     = cs_pkg::STEP_W;
    localparam int CW     = cs_pkg::COS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_CHECK,
        S_NORM,
        S_SQR,
        S_DIV,
        S_ROOT,
        S_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [TW-1:0]             step_reg, step_next;
    logic [DW-1:0]             dot_reg, dot_next;
    logic [SW-1:0]             saa_reg, saa_next;
    logic [SW-1:0]             sbb_reg, sbb_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CW-1:0]             cos_reg, cos_next;
    logic [DW-1:0]             dotp_reg, dotp_next;
    cs_pkg::status_t           status_reg, status_next;

    logic signed [ELEM_BITS-1:0] a_reg, a_next;
    logic signed [ELEM_BITS-1:0] b_reg, b_next;
    logic                        last_reg, last_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        neg_reg, neg_next;
    logic [DW-1:0]               mag_reg, mag_next;
    logic [AW-1:0]               shf_reg, shf_next;
    logic [DW-1:0]               mpl_reg, mpl_next;
    logic [AW-1:0]               div_reg, div_next;
    logic [AW-1:0]               rem_reg, rem_next;
    logic [QW-1:0]               quo_reg, quo_next;
    logic [OW-1:0]               op_reg, op_next;
    logic [OW-1:0]               res_reg, res_next;
    logic [OW-1:0]               bit_reg, bit_next;
    logic [CW-1:0]               rcos_reg, rcos_next;
    cs_pkg::status_t             rst_reg, rst_next;

    logic [RAW_W-1:0]            a_raw, b_raw;
    logic signed [ELEM_BITS-1:0] mul_x, mul_y;
    logic signed [PROD_W-1:0]    mul_out;
    logic [AW-1:0]               prod_ext;
    logic [AW-1:0]               alu_x, alu_y, alu_sum;
    logic                        alu_sub, alu_carry;
    logic [OW-1:0]               root_new;
    logic [QW-1:0]               quo_new;
    logic [RW:0]                 m_full;
    logic [CW-1:0]               m_val;

    cs_addsub #(.W(AW)) u_addsub (
        .x     (alu_x),
        .y     (alu_y),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign a_raw    = RAW_W'($unsigned(req.a_elem));
    assign b_raw    = RAW_W'($unsigned(req.b_elem));
    assign mul_out  = PROD_W'(mul_x) * PROD_W'(mul_y);
    assign prod_ext = {{(AW - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign quo_new  = {quo_reg[QW-2:0], alu_carry};
    assign root_new = alu_carry ? ((res_reg >> 1) | bit_reg) : (res_reg >> 1);
    assign m_full   = quo_reg[QW-1] ? (RW+1)'(1 << (CW - 1))
                                    : (({1'b0, root_new[RW-1:0]} + (RW+1)'(1)) >> 1);
    assign m_val    = CW'(m_full);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.cosine      = cos_reg;
    assign rsp.dot_product = dotp_reg;
    assign rsp.status      = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        dot_next       = dot_reg;
        saa_next       = saa_reg;
        sbb_next       = sbb_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        cos_next       = cos_reg;
        dotp_next      = dotp_reg;
        status_next    = status_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        shf_next       = shf_reg;
        mpl_next       = mpl_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        op_next        = op_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        rcos_next      = rcos_reg;
        rst_next       = rst_reg;
        alu_x          = '0;
        alu_y          = '0;
        alu_sub        = 1'b0;
        mul_x          = a_reg;
        mul_y          = b_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    a_next    = a_raw[ELEM_BITS-1:0];
                    b_next    = b_raw[ELEM_BITS-1:0];
                    last_next = req.last;
                    if (cnt_reg < CNT_W'(MAX_LEN))
                    begin
                        step_next  = '0;
                        state_next = S_MAC;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = req.last ? S_CHECK : S_IDLE;
                    end
                end
            end

            S_MAC:
            begin
                // products: a*b, a*a, b*b; each accumulated from prod_reg in the next step
                if (step_reg == TW'(1))
                begin
                    mul_y = a_reg;
                end
                else if (step_reg == TW'(2))
                begin
                    mul_x = b_reg;
                end
                prod_next = mul_out;
                alu_y     = prod_ext;
                step_next = step_reg + TW'(1);
                if (step_reg == TW'(1))
                begin
                    alu_x    = AW'(dot_reg);
                    dot_next = alu_sum[DW-1:0];
                end
                else if (step_reg == TW'(2))
                begin
                    alu_x    = AW'(saa_reg);
                    saa_next = alu_sum[SW-1:0];
                end
                else if (step_reg == TW'(3))
                begin
                    alu_x      = AW'(sbb_reg);
                    sbb_next   = alu_sum[SW-1:0];
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = last_reg ? S_CHECK : S_IDLE;
                end
            end

            S_CHECK:
            begin
                alu_y   = AW'(dot_reg);
                alu_sub = 1'b1;
                if (ovf_reg)
                begin
                    rst_next   = cs_pkg::ST_LEN;
                    rcos_next  = '0;
                    state_next = S_OUT;
                end
                else if (saa_reg == '0 || sbb_reg == '0)
                begin
                    rst_next   = cs_pkg::ST_ZERO;
                    rcos_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    neg_next   = dot_reg[DW-1];
                    mag_next   = dot_reg[DW-1] ? alu_sum[DW-1:0] : dot_reg;
                    shf_next   = AW'(saa_reg);
                    mpl_next   = DW'(sbb_reg);
                    div_next   = '0;
                    step_next  = '0;
                    state_next = S_NORM;
                end
            end

            S_NORM:
            begin
                // shift-add sum_aa * sum_bb into div
                alu_x     = div_reg;
                alu_y     = shf_reg;
                shf_next  = shf_reg << 1;
                mpl_next  = mpl_reg >> 1;
                step_next = step_reg + TW'(1);
                if (mpl_reg[0])
                begin
                    div_next = alu_sum;
                end
                if (step_reg == TW'(SW - 1))
                begin
                    div_next   = (mpl_reg[0] ? alu_sum : div_reg) << cs_pkg::SCALE_SH;
                    shf_next   = AW'(mag_reg);
                    mpl_next   = mag_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_SQR;
                end
            end

            S_SQR:
            begin
                alu_x     = rem_reg;
                alu_y     = shf_reg;
                shf_next  = shf_reg << 1;
                mpl_next  = mpl_reg >> 1;
                step_next = step_reg + TW'(1);
                if (mpl_reg[0])
                begin
                    rem_next = alu_sum;
                end
                if (step_reg == TW'(DW - 1))
                begin
                    rem_next   = (mpl_reg[0] ? alu_sum : rem_reg) << cs_pkg::SCALE_SH;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // quotient floor(dot^2 * 2^32 / p); top bit set means saturate
                alu_x     = rem_reg;
                alu_y     = div_reg;
                alu_sub   = 1'b1;
                quo_next  = quo_new;
                div_next  = div_reg >> 1;
                step_next = step_reg + TW'(1);
                if (alu_carry)
                begin
                    rem_next = alu_sum;
                end
                if (step_reg == TW'(QW - 1))
                begin
                    op_next    = quo_new[OW-1:0];
                    res_next   = '0;
                    bit_next   = OW'(1) << (OW - 2);
                    step_next  = '0;
                    state_next = S_ROOT;
                end
            end

            S_ROOT:
            begin
                alu_x     = AW'(op_reg);
                alu_y     = AW'(res_reg | bit_reg);
                alu_sub   = 1'b1;
                res_next  = root_new;
                bit_next  = bit_reg >> 2;
                step_next = step_reg + TW'(1);
                if (alu_carry)
                begin
                    op_next = alu_sum[OW-1:0];
                end
                if (step_reg == TW'(RW - 1))
                begin
                    // m = (isqrt + 1) / 2, capped at one
                    rst_next = cs_pkg::ST_OK;
                    if (neg_reg)
                    begin
                        rcos_next = ~m_val + CW'(1);
                    end
                    else if (m_val[CW-1])
                    begin
                        rcos_next = {1'b0, {(CW - 1){1'b1}}};
                    end
                    else
                    begin
                        rcos_next = m_val;
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    cos_next       = rcos_reg;
                    dotp_next      = dot_reg;
                    status_next    = rst_reg;
                    dot_next       = '0;
                    saa_next       = '0;
                    sbb_next       = '0;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            dot_reg       <= '0;
            saa_reg       <= '0;
            sbb_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            cos_reg       <= '0;
            dotp_reg      <= '0;
            status_reg    <= cs_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dot_reg       <= dot_next;
            saa_reg       <= saa_next;
            sbb_reg       <= sbb_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            cos_reg       <= cos_next;
            dotp_reg      <= dotp_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        last_reg <= last_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        shf_reg  <= shf_next;
        mpl_reg  <= mpl_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        op_reg   <= op_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        rcos_reg <= rcos_next;
        rst_reg  <= rst_next;
    end

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.last || cnt_reg < CNT_W'(MAX_LEN))) |=> !req.ready)
        else $error("request taken while previous one still in work");

    a_flag_cos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == cs_pkg::ST_ZERO || rsp.status == cs_pkg::ST_LEN))
        |-> (rsp.cosine == '0))
        else $error("flagged result with non-zero cosine");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_reg != '0))
        else $error("divisor reached zero");

endmodule
